@@ rtl/core/tcw_pkg.sv @@
// Shared constants, payload types and controller/datapath interface types of the text console.
package tcw_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = ROWS * COLUMNS;
  localparam int SHIFT_CELLS = (ROWS - 1) * COLUMNS;
  localparam int COL_W       = $clog2(COLUMNS);
  localparam int ROW_W       = $clog2(ROWS);
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int CNT_W       = $clog2(CELLS + 1);
  localparam int TAB_STEP    = 8;

  localparam int FUNC_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int CURSOR_W = 11;
  localparam int ATTR_W   = 8;
  localparam int CELL_W   = ATTR_W + CHAR_W;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_position;
    logic [CELL_W-1:0]   read_value;
  } tcw_out_t;

  typedef enum logic [1:0] {
    WR_COPY  = 2'd0,
    WR_BLANK = 2'd1,
    WR_RESET = 2'd2
  } wr_src_e;

  typedef struct packed {
    logic    accept;
    logic    sweep_step;
    wr_src_e sweep_src;
    logic    resp_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic item_scroll;
    logic item_clear;
    logic sweep_last_copy;
    logic sweep_last_cell;
    logic out_free;
  } tcw_sts_t;

endpackage

@@ rtl/core/tcw_ctrl.sv @@
// Sequencer for request intake, clearing pass, scroll sweep and result hand-off.
module tcw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcw_pkg::tcw_sts_t sts_i,
  output tcw_pkg::tcw_cmd_t cmd_o
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_SETTLE,
    ST_IDLE,
    ST_COPY,
    ST_FILL,
    ST_RESP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.sweep_step = 1'b1;
        cmd_o.sweep_src  = WR_RESET;
        if (sts_i.sweep_last_cell) begin
          state_d = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.item_clear) begin
            state_d = ST_FILL;
          end else if (sts_i.item_scroll) begin
            state_d = ST_COPY;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_COPY: begin
        cmd_o.sweep_step = 1'b1;
        cmd_o.sweep_src  = WR_COPY;
        if (sts_i.sweep_last_copy) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd_o.sweep_step = 1'b1;
        cmd_o.sweep_src  = WR_BLANK;
        if (sts_i.sweep_last_cell) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.resp_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/tcw_datapath.sv @@
// Cell store, cursor, attribute register, sweep counter and result register.
module tcw_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcw_pkg::tcw_in_t            in_data_i,
  output tcw_pkg::tcw_out_t           out_data_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data_i,
  input  tcw_pkg::tcw_cmd_t           cmd_i,
  output tcw_pkg::tcw_sts_t           sts_o
);
  import tcw_pkg::*;

  logic [CELL_W-1:0]   mem_q [CELLS];
  logic [CELL_W-1:0]   rd_data_q;
  logic [ATTR_W-1:0]   attr_q;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [CNT_W-1:0]    cnt_q;
  logic                wr_pend_q;
  logic [ADDR_W-1:0]   wr_addr_q;
  wr_src_e             wr_src_q;
  logic                rd_hit_q;
  logic                out_valid_q;
  tcw_out_t            out_data_q;

  logic [COL_W:0]      col_ext;
  logic [COL_W:0]      col_sum;
  logic                row_adv;
  logic                scroll;
  logic                put_wr;
  logic                rd_hit;
  logic [ADDR_W-1:0]   cursor_lin;
  logic [CURSOR_W-1:0] pos_wide;
  logic [CELL_W-1:0]   blank_attr;
  logic [CELL_W-1:0]   blank_reset;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [ADDR_W-1:0]   sweep_addr;

  assign col_ext     = {1'b0, col_q};
  assign cursor_lin  = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
  assign pos_wide    = CURSOR_W'(cursor_lin);
  assign blank_attr  = {attr_q, CHAR_SPACE};
  assign blank_reset = {ATTR_RESET, CHAR_SPACE};
  assign sweep_addr  = cnt_q[ADDR_W-1:0];
  assign rd_hit      = (in_data_i.func == FUNC_READ) && (32'(in_data_i.cell_index) < CELLS);

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    col_sum = '0;
    row_adv = 1'b0;
    scroll  = 1'b0;
    put_wr  = 1'b0;
    if (in_data_i.func == FUNC_PUT) begin
      case (in_data_i.char_code)
        CHAR_BS: begin
          if (col_q != '0) begin
            col_d = col_q - 1'b1;
          end
        end
        CHAR_TAB: begin
          col_sum = (col_ext + (COL_W + 1)'(TAB_STEP)) & ~((COL_W + 1)'(TAB_STEP - 1));
          if (col_sum >= (COL_W + 1)'(COLUMNS)) begin
            row_adv = 1'b1;
          end else begin
            col_d = col_sum[COL_W-1:0];
          end
        end
        CHAR_CR: begin
          col_d = '0;
        end
        CHAR_LF: begin
          row_adv = 1'b1;
        end
        default: begin
          put_wr  = 1'b1;
          col_sum = col_ext + 1'b1;
          if (col_sum >= (COL_W + 1)'(COLUMNS)) begin
            row_adv = 1'b1;
          end else begin
            col_d = col_sum[COL_W-1:0];
          end
        end
      endcase
      if (row_adv) begin
        col_d = '0;
        if (row_q == ROW_W'(ROWS - 1)) begin
          scroll = 1'b1;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
    end else if (in_data_i.func == FUNC_CLEAR) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cursor_lin;
    mem_wdata = {attr_q, in_data_i.char_code};
    if (wr_pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_q;
      case (wr_src_q)
        WR_COPY:  mem_wdata = rd_data_q;
        WR_BLANK: mem_wdata = blank_attr;
        WR_RESET: mem_wdata = blank_reset;
        default:  mem_wdata = blank_reset;
      endcase
    end else if (cmd_i.accept && put_wr) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = ADDR_W'(in_data_i.cell_index);
    if (cmd_i.accept && rd_hit) begin
      mem_re = 1'b1;
    end else if (cmd_i.sweep_step && (cmd_i.sweep_src == WR_COPY)) begin
      mem_re    = 1'b1;
      mem_raddr = sweep_addr + ADDR_W'(COLUMNS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= ATTR_RESET;
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      wr_pend_q   <= 1'b0;
      rd_hit_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        attr_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        col_q    <= col_d;
        row_q    <= row_d;
        rd_hit_q <= rd_hit;
        cnt_q    <= '0;
      end else if (cmd_i.sweep_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      wr_pend_q <= cmd_i.sweep_step;
      if (cmd_i.resp_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_step) begin
      wr_addr_q <= sweep_addr;
      wr_src_q  <= cmd_i.sweep_src;
    end
    if (cmd_i.resp_load) begin
      out_data_q.cursor_position <= pos_wide;
      out_data_q.read_value      <= rd_hit_q ? rd_data_q : '0;
    end
  end

  assign sts_o.item_scroll     = scroll;
  assign sts_o.item_clear      = (in_data_i.func == FUNC_CLEAR);
  assign sts_o.sweep_last_copy = (cnt_q == CNT_W'(SHIFT_CELLS - 1));
  assign sts_o.sweep_last_cell = (cnt_q == CNT_W'(CELLS - 1));
  assign sts_o.out_free        = !out_valid_q || out_ready_i;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/core/text_console_writer.sv @@
// Top level of the text console: controller and datapath joined by command and status.
// A put without scroll, a read or an unused code passes through the registered store read and the
// result register; a new request is taken only once the result of the last one has been loaded.
// A scroll sweeps the store through its one read and one write port.
// A clear blanks one cell a cycle.
// After reset a clearing pass blanks the store; no request is taken meanwhile.
module text_console_writer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tcw_pkg::tcw_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tcw_pkg::tcw_out_t           out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data_i
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

@@ rtl/core/tcw_checker.sv @@
// Port-level checks of the text console and their binding to the top level.
module tcw_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input tcw_pkg::tcw_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input tcw_pkg::tcw_out_t out_data_o
);
  import tcw_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o && (in_data_i.func == FUNC_READ)
    |-> ##2 out_valid_o)
    else $error("read result late");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_data_o.cursor_position) < CELLS))
    else $error("cursor position out of range");

endmodule

bind text_console_writer tcw_checker u_checker (.*);
